### hdl/ptc_pkg.sv
// Shared types, register codes and rounding helpers for the pressure and
// temperature compensation block. No dependencies.
package ptc_pkg;

  localparam int ADDR_W = 5;
  localparam int NUM_W  = 62;
  localparam int DSR_W  = 37;
  localparam int QUO_W  = 26;

  localparam logic [2:0] REG_T1  = 3'd0;
  localparam logic [2:0] REG_T23 = 3'd1;
  localparam logic [2:0] REG_P1  = 3'd2;
  localparam logic [2:0] REG_P23 = 3'd3;
  localparam logic [2:0] REG_P45 = 3'd4;
  localparam logic [2:0] REG_P67 = 3'd5;
  localparam logic [2:0] REG_P89 = 3'd6;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [23:0]        pressure_centi_pa;
    logic               pressure_valid;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic [NUM_W-1:0]   rem;
    logic [DSR_W-1:0]   dsr;
    logic [QUO_W-1:0]   quo;
    logic               neg;
    logic               ovf;
    logic               zero;
  } div_word_t;

  // Divide by 2^k, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned k);
    logic signed [63:0] half;
    half = 64'sd1 <<< (k - 1);
    return (v + half - $signed({63'd0, v[63]})) >>> k;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

### hdl/pressure_temperature_compensation.sv
// Top level: calibration registers, stall control and the three pipeline parts.
// Depends on ptc_pkg, ptc_front, ptc_div and ptc_back.
//
//   channel  ports                                  carries
//   input    in_valid, in_ready, in_data            raw pressure and temperature
//   output   out_valid, out_ready, out_data         compensated results
//   config   psel, penable, pwrite, paddr, ...      calibration coefficients
//
// One word enters per cycle unless the pipeline is stalled; each word passes the
// front, the divider, which resolves one quotient bit per stage, and the back.
// The whole pipeline advances whenever the output register is empty or taken.
// A stall holds every stage; nothing is lost or repeated.
// Reset is synchronous and clears the coefficients and the valid bits.
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] t1_r, p1_r;
  logic [31:0] t23_r, p23_r, p45_r, p67_r, p89_r;
  logic        wr_en, en;
  logic [2:0]  idx;
  coef_t       coef;
  logic        f_valid, d_valid;
  div_word_t   f_word, d_word;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t23_r <= '0;
      p1_r  <= '0;
      p23_r <= '0;
      p45_r <= '0;
      p67_r <= '0;
      p89_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_T1:  t1_r  <= pwdata[15:0];
        REG_T23: t23_r <= pwdata;
        REG_P1:  p1_r  <= pwdata[15:0];
        REG_P23: p23_r <= pwdata;
        REG_P45: p45_r <= pwdata;
        REG_P67: p67_r <= pwdata;
        REG_P89: p89_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T1:  prdata = {16'd0, t1_r};
      REG_T23: prdata = t23_r;
      REG_P1:  prdata = {16'd0, p1_r};
      REG_P23: prdata = p23_r;
      REG_P45: prdata = p45_r;
      REG_P67: prdata = p67_r;
      REG_P89: prdata = p89_r;
      default: prdata = 32'd0;
    endcase
  end

  always_comb begin
    coef.t1 = t1_r;
    coef.t2 = t23_r[15:0];
    coef.t3 = t23_r[31:16];
    coef.p1 = p1_r;
    coef.p2 = p23_r[15:0];
    coef.p3 = p23_r[31:16];
    coef.p4 = p45_r[15:0];
    coef.p5 = p45_r[31:16];
    coef.p6 = p67_r[15:0];
    coef.p7 = p67_r[31:16];
    coef.p8 = p89_r[15:0];
    coef.p9 = p89_r[31:16];
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .coef      (coef),
    .out_valid (f_valid),
    .out_word  (f_word)
  );

  ptc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_word   (f_word),
    .out_valid (d_valid),
    .out_word  (d_word)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_word   (d_word),
    .coef      (coef),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

`ifndef SYNTHESIS
  a_invalid_pressure_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pressure_valid |-> out_data.pressure_centi_pa == 24'd0)
    else $error("pressure not zero for a zero divisor");

  a_t1_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && idx == REG_T1 |=> t1_r == $past(pwdata[15:0]))
    else $error("coefficient write not stored");
`endif

endmodule

### hdl/ptc_front.sv
// Front pipeline: temperature polynomial, pressure offset and divisor terms,
// and divider operand preparation. Depends on ptc_pkg.
module ptc_front import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  in_word_t  in_data,
  input  coef_t     coef,
  output logic      out_valid,
  output div_word_t out_word
);

  logic [10:0]        vld_r;
  logic [19:0]        pr_r [1:8];
  logic signed [15:0] tc_r [4:10];
  logic signed [41:0] ap5_r [5:7];
  logic signed [41:0] p2a_r [5:7];

  logic signed [20:0] d_r, d_nxt;
  logic signed [41:0] dd_r, dd_nxt;
  logic signed [36:0] dt2_r, dt2_nxt;
  logic signed [59:0] nt_r, nt_nxt;
  logic signed [15:0] tc_nxt;
  logic signed [25:0] a_r, a_nxt;
  logic signed [49:0] aa_r, aa_nxt;
  logic signed [41:0] ap5_nxt, p2a_nxt;
  logic signed [45:0] s4_r, s4_nxt;
  logic signed [61:0] s4p6_r, s4p6_nxt, s4p3_r, s4p3_nxt;
  logic signed [45:0] b_r, b_nxt;
  logic signed [46:0] c8_r, c8_nxt;
  logic signed [63:0] p1c8_r, p1c8_nxt;
  logic signed [47:0] num_r, num_nxt;
  logic signed [37:0] den_r, den_nxt;
  logic signed [63:0] numk_r, numk_nxt;
  logic signed [16:0] p1s;
  logic [20:0]        pw;
  logic [63:0]        mn, nrm;
  logic [37:0]        md;
  div_word_t          ow_r, ow_nxt;

  always_comb begin
    p1s      = $signed({1'b0, coef.p1});
    d_nxt    = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, coef.t1, 4'b0000});
    dd_nxt   = 42'(d_r) * 42'(d_r);
    dt2_nxt  = 37'(d_r) * 37'(coef.t2);
    nt_nxt   = (60'(dt2_r) <<< 20) + 60'(dd_r) * 60'(coef.t3);
    tc_nxt   = 16'(clamp(rnd_shift(64'(nt_r) * 64'sd5, 42), -64'sd32768, 64'sd32767));
    a_nxt    = 26'(clamp(rnd_shift(64'(nt_r), 31) - 64'sd1024000,
                         -64'sd16777216, 64'sd16777216));
    aa_nxt   = 50'(a_r) * 50'(a_r);
    ap5_nxt  = 42'(a_r) * 42'(coef.p5);
    p2a_nxt  = 42'(a_r) * 42'(coef.p2);
    s4_nxt   = 46'(rnd_shift(64'(aa_r), 4));
    s4p6_nxt = 62'(s4_r) * 62'(coef.p6);
    s4p3_nxt = 62'(s4_r) * 62'(coef.p3);
    b_nxt    = 46'(rnd_shift(64'(s4p6_r), 17) + rnd_shift(64'(ap5_r[7]), 1)
                   + (64'(coef.p4) <<< 20));
    c8_nxt   = 47'(rnd_shift(64'(s4p3_r), 15) + (64'(p2a_r[7]) <<< 4));
    p1c8_nxt = 64'(p1s) * 64'(c8_r);
    pw       = 21'h100000 - {1'b0, pr_r[8]};
    num_nxt  = $signed({11'd0, pw, 16'd0}) - 48'(b_r);
    den_nxt  = 38'((64'(p1s) <<< 16) + rnd_shift(p1c8_r, 26));
    numk_nxt = 64'(num_r) * 64'sd100000;

    mn  = numk_r[63] ? 64'(-numk_r) : 64'(numk_r);
    md  = den_r[37] ? 38'(-den_r) : 38'(den_r);
    nrm = (mn << 1) + 64'(md);
    ow_nxt.tc   = tc_r[10];
    ow_nxt.rem  = nrm[NUM_W-1:0];
    ow_nxt.dsr  = DSR_W'({md, 1'b0});
    ow_nxt.quo  = '0;
    ow_nxt.neg  = numk_r[63] ^ den_r[37];
    ow_nxt.zero = (den_r == 38'sd0);
    // The quotient has QUO_W bits only when the dividend is below dsr * 2^QUO_W.
    ow_nxt.ovf  = ({1'b0, ow_nxt.rem} >= {ow_nxt.dsr, {QUO_W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      pr_r[1]  <= in_data.raw_pressure;
      for (int i = 2; i <= 8; i++) pr_r[i] <= pr_r[i-1];
      dd_r     <= dd_nxt;
      dt2_r    <= dt2_nxt;
      nt_r     <= nt_nxt;
      tc_r[4]  <= tc_nxt;
      for (int i = 5; i <= 10; i++) tc_r[i] <= tc_r[i-1];
      a_r      <= a_nxt;
      aa_r     <= aa_nxt;
      ap5_r[5] <= ap5_nxt;
      p2a_r[5] <= p2a_nxt;
      for (int i = 6; i <= 7; i++) begin
        ap5_r[i] <= ap5_r[i-1];
        p2a_r[i] <= p2a_r[i-1];
      end
      s4_r     <= s4_nxt;
      s4p6_r   <= s4p6_nxt;
      s4p3_r   <= s4p3_nxt;
      b_r      <= b_nxt;
      c8_r     <= c8_nxt;
      p1c8_r   <= p1c8_nxt;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      numk_r   <= numk_nxt;
      ow_r     <= ow_nxt;
    end
  end

  assign out_valid = vld_r[10];
  assign out_word  = ow_r;

endmodule

### hdl/ptc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ptc_pkg.
module ptc_div import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  div_word_t in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  logic [QUO_W-1:0] vld_r;
  div_word_t        st_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int Bit = QUO_W - 1 - k;
    div_word_t    src, st_nxt;
    logic [NUM_W:0] trial;

    if (k == 0) begin : g_first
      assign src = in_word;
    end else begin : g_next
      assign src = st_r[k-1];
    end

    always_comb begin
      st_nxt = src;
      trial  = {1'b0, src.rem} - ({1'b0, NUM_W'(src.dsr)} << Bit);
      if (!trial[NUM_W]) begin
        st_nxt.rem      = trial[NUM_W-1:0];
        st_nxt.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_word  = st_r[QUO_W-1];

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.ovf && !out_word.zero |-> out_word.rem < NUM_W'(out_word.dsr))
    else $error("divider remainder not below divisor");
`endif

endmodule

### hdl/ptc_back.sv
// Back pipeline: signed quotient, second-order pressure correction,
// scaling to 0.01 Pa and saturation. Depends on ptc_pkg.
module ptc_back import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  div_word_t in_word,
  input  coef_t     coef,
  output logic      out_valid,
  output out_word_t out_word
);

  logic [6:0]         vld_r;
  logic signed [15:0] tc_r [1:6];
  logic               zr_r [1:6];
  logic signed [26:0] x4_r [1:5];
  logic signed [42:0] p8x4_r [2:4];

  logic [QUO_W-1:0]   qm;
  logic signed [26:0] x4_nxt;
  logic signed [53:0] xx_r, xx_nxt;
  logic signed [42:0] p8x4_nxt;
  logic signed [43:0] xs_r, xs_nxt;
  logic signed [59:0] p9xs_r, p9xs_nxt;
  logic signed [32:0] s_r, s_nxt;
  logic signed [28:0] pq4_r, pq4_nxt;
  out_word_t          ow_r, ow_nxt;

  always_comb begin
    qm = (in_word.ovf || in_word.quo > QUO_W'(33554432)) ? QUO_W'(33554432) : in_word.quo;
    x4_nxt   = in_word.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    xx_nxt   = 54'(x4_r[1]) * 54'(x4_r[1]);
    p8x4_nxt = 43'(x4_r[1]) * 43'(coef.p8);
    xs_nxt   = 44'(rnd_shift(64'(xx_r), 8));
    p9xs_nxt = 60'(xs_r) * 60'(coef.p9);
    s_nxt    = 33'(rnd_shift(64'(p9xs_r), 27) + rnd_shift(64'(p8x4_r[4]), 15)
                   + (64'(coef.p7) <<< 4));
    pq4_nxt  = 29'(64'(x4_r[5]) + rnd_shift(64'(s_r), 4));
    ow_nxt.temperature_centi = tc_r[6];
    ow_nxt.pressure_valid    = !zr_r[6];
    ow_nxt.pressure_centi_pa = zr_r[6] ? 24'd0 :
      24'(clamp(rnd_shift(64'(pq4_r) * 64'sd25, 2), 64'sd0, 64'sd16777215));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc_r[1]   <= in_word.tc;
      zr_r[1]   <= in_word.zero;
      for (int i = 2; i <= 6; i++) begin
        tc_r[i] <= tc_r[i-1];
        zr_r[i] <= zr_r[i-1];
      end
      x4_r[1]   <= x4_nxt;
      for (int i = 2; i <= 5; i++) x4_r[i] <= x4_r[i-1];
      xx_r      <= xx_nxt;
      p8x4_r[2] <= p8x4_nxt;
      for (int i = 3; i <= 4; i++) p8x4_r[i] <= p8x4_r[i-1];
      xs_r      <= xs_nxt;
      p9xs_r    <= p9xs_nxt;
      s_r       <= s_nxt;
      pq4_r     <= pq4_nxt;
      ow_r      <= ow_nxt;
    end
  end

  assign out_valid = vld_r[6];
  assign out_word  = ow_r;

endmodule

### dv/tb_pressure_temperature_compensation.sv
// Self-checking testbench for pressure_temperature_compensation: drives raw readings,
// programs the calibration coefficients over the APB-style port and checks every word.
// Depends on ptc_pkg and the RTL of the block; it reads no files.
module tb_pressure_temperature_compensation;
  import ptc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CFG = 7;
  localparam longint CYCLE_LIMIT = 600000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  pressure_temperature_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [31:0] coef_shadow [NUM_CFG];
  out_word_t   pending_results [$];
  out_word_t   typed_results [$];
  bit          use_typed;
  int          error_count;
  int          mismatch_count;
  longint      cycle_count;
  bit          quiet_phase;
  bit          long_hold;

  typedef struct {
    int        setting;
    in_word_t  word;
    bit        has_typed;
    out_word_t typed;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int k);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (k - 1))) >> k;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_divide(longint n, longint dv);
    longint unsigned mn, md, q;
    mn = (n < 0) ? longint'(-n) : n;
    md = (dv < 0) ? longint'(-dv) : dv;
    q = (2 * mn + md) / (2 * md);
    return ((n < 0) != (dv < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint coef_half(int idx, bit hi);
    logic [15:0] h;
    h = hi ? coef_shadow[idx][31:16] : coef_shadow[idx][15:0];
    return longint'($signed(h));
  endfunction

  function automatic out_word_t compensate(in_word_t w);
    longint praw, traw, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d, nt, tc, a, s4, b, c8, den, num, x4, xs, s, pq4, pc;
    out_word_t r;
    praw = longint'(w.raw_pressure);
    traw = longint'(w.raw_temperature);
    t1 = longint'(coef_shadow[REG_T1][15:0]);
    t2 = coef_half(REG_T23, 0);
    t3 = coef_half(REG_T23, 1);
    p1 = longint'(coef_shadow[REG_P1][15:0]);
    p2 = coef_half(REG_P23, 0);
    p3 = coef_half(REG_P23, 1);
    p4 = coef_half(REG_P45, 0);
    p5 = coef_half(REG_P45, 1);
    p6 = coef_half(REG_P67, 0);
    p7 = coef_half(REG_P67, 1);
    p8 = coef_half(REG_P89, 0);
    p9 = coef_half(REG_P89, 1);
    d = traw - 16 * t1;
    nt = d * t2 * 1048576 + d * d * t3;
    tc = saturate(round_shift(nt * 5, 42), -32768, 32767);
    a = saturate(round_shift(nt, 31) - 1024000, -16777216, 16777216);
    s4 = round_shift(a * a, 4);
    b = round_shift(s4 * p6, 17) + round_shift(a * p5, 1) + p4 * 1048576;
    c8 = round_shift(s4 * p3, 15) + p2 * a * 16;
    den = p1 * 65536 + round_shift(p1 * c8, 26);
    pc = 0;
    r.pressure_valid = 1'b0;
    if (den != 0) begin
      num = (1048576 - praw) * 65536 - b;
      x4 = saturate(round_divide(num * 100000, den), -33554432, 33554432);
      xs = round_shift(x4 * x4, 8);
      s = round_shift(p9 * xs, 27) + round_shift(p8 * x4, 15) + p7 * 16;
      pq4 = x4 + round_shift(s, 4);
      pc = saturate(round_shift(pq4 * 25, 2), 0, 16777215);
      r.pressure_valid = 1'b1;
    end
    r.temperature_centi = tc[15:0];
    r.pressure_centi_pa = pc[23:0];
    return r;
  endfunction

  // Accepted words are predicted with the coefficients in force at acceptance.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (use_typed && typed_results.size() > 0)
        pending_results.push_back(typed_results.pop_front());
      else
        pending_results.push_back(compensate(in_data));
    end
  end

  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word %h", out_data);
      end else begin
        exp_word = pending_results.pop_front();
        if (out_data.temperature_centi !== exp_word.temperature_centi ||
            out_data.pressure_centi_pa !== exp_word.pressure_centi_pa ||
            out_data.pressure_valid !== exp_word.pressure_valid) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected t=%0d p=%0d v=%0d, got t=%0d p=%0d v=%0d",
                     exp_word.temperature_centi, exp_word.pressure_centi_pa,
                     exp_word.pressure_valid, out_data.temperature_centi,
                     out_data.pressure_centi_pa, out_data.pressure_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_pressure_temperature_compensation failed");
      $finish;
    end
  end

  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (long_hold) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic write_coef(int idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * idx);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_T1 || idx == REG_P1)
      coef_shadow[idx] = {16'd0, value[15:0]};
    else if (idx < NUM_CFG)
      coef_shadow[idx] = value;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic load_setting(int setting);
    case (setting)
      0: begin
        write_coef(REG_T1, 32'hABCD_6B70);
        write_coef(REG_T23, 32'hFC18_6743);
        write_coef(REG_P1, 32'h0000_8E7D);
        write_coef(REG_P23, 32'h0BD0_D643);
        write_coef(REG_P45, 32'h008C_0B27);
        write_coef(REG_P67, 32'h3C8C_FFF9);
        write_coef(REG_P89, 32'h1770_C6F8);
        write_coef(7, 32'hDEAD_BEEF);
      end
      1: begin
        write_coef(REG_T1, 32'h0000_0000);
        write_coef(REG_T23, 32'h7FFF_7FFF);
        write_coef(REG_P1, 32'h0000_0001);
        write_coef(REG_P23, 32'h0000_C000);
        write_coef(REG_P45, 32'h7FFF_7FFF);
        write_coef(REG_P67, 32'h7FFF_7FFF);
        write_coef(REG_P89, 32'h7FFF_7FFF);
      end
      2: begin
        write_coef(REG_T1, 32'h0000_FFFF);
        write_coef(REG_T23, 32'h8000_8000);
        write_coef(REG_P1, 32'h0000_FFFF);
        write_coef(REG_P23, 32'h8000_8000);
        write_coef(REG_P45, 32'h8000_8000);
        write_coef(REG_P67, 32'h8000_8000);
        write_coef(REG_P89, 32'h8000_8000);
      end
      3: begin
        for (int i = 0; i < NUM_CFG; i++) write_coef(i, $urandom);
      end
      default: begin
        write_coef(REG_T1, 32'h6B70 + $urandom_range(0, 400) - 200);
        write_coef(REG_T23, {16'hFC18 + 16'($urandom_range(0, 200)),
                             16'h6743 + 16'($urandom_range(0, 400))});
        write_coef(REG_P1, 32'h8E7D + $urandom_range(0, 800) - 400);
        write_coef(REG_P23, {16'h0BD0 + 16'($urandom_range(0, 200)),
                             16'hD643 + 16'($urandom_range(0, 400))});
        write_coef(REG_P45, {16'h008C, 16'h0B27 + 16'($urandom_range(0, 300))});
        write_coef(REG_P67, {16'h3C8C + 16'($urandom_range(0, 500)), 16'hFFF9});
        write_coef(REG_P89, {16'h1770 + 16'($urandom_range(0, 300)),
                             16'hC6F8 + 16'($urandom_range(0, 300))});
      end
    endcase
  endtask

  function automatic in_word_t random_reading();
    in_word_t w;
    if ($urandom_range(0, 9) < 7) begin
      w.raw_pressure = 20'h655AC + 20'($urandom_range(0, 65535)) - 20'd32768;
      w.raw_temperature = 20'h7EED0 + 20'($urandom_range(0, 65535)) - 20'd32768;
    end else begin
      w.raw_pressure = 20'($urandom);
      w.raw_temperature = 20'($urandom);
    end
    return w;
  endfunction

  function automatic out_word_t typed_word(logic signed [15:0] t, logic [23:0] p, logic v);
    out_word_t r;
    r.temperature_centi = t;
    r.pressure_centi_pa = p;
    r.pressure_valid = v;
    return r;
  endfunction

  function automatic in_word_t reading(logic [19:0] p, logic [19:0] t);
    in_word_t w;
    w.raw_pressure = p;
    w.raw_temperature = t;
    return w;
  endfunction

  initial begin
    stim_row_t rows [$];
    int current_setting;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    use_typed = 1'b0;
    quiet_phase = 1'b0;
    long_hold = 1'b0;
    error_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    for (int i = 0; i < NUM_CFG; i++) coef_shadow[i] = '0;

    // With all coefficients zero the divisor is zero and the temperature is zero.
    rows.push_back('{-1, reading(20'h00000, 20'h00000), 1, typed_word(0, 0, 0)});
    rows.push_back('{-1, reading(20'hFFFFF, 20'hFFFFF), 1, typed_word(0, 0, 0)});
    rows.push_back('{-1, reading(20'hFFFFF, 20'h00000), 1, typed_word(0, 0, 0)});
    rows.push_back('{-1, reading(20'h00000, 20'hFFFFF), 1, typed_word(0, 0, 0)});
    rows.push_back('{0, reading(20'h655AC, 20'h7EED0), 0, '0});
    rows.push_back('{0, reading(20'h00000, 20'h00000), 0, '0});
    rows.push_back('{0, reading(20'hFFFFF, 20'hFFFFF), 0, '0});
    rows.push_back('{0, reading(20'hAAAAA, 20'h55555), 0, '0});
    rows.push_back('{0, reading(20'h55555, 20'hAAAAA), 0, '0});
    // Huge temperature term: clamped, temperature saturates and the divisor is zero.
    rows.push_back('{1, reading(20'h00000, 20'hFFFFF), 1, typed_word(32767, 0, 0)});
    rows.push_back('{1, reading(20'hFFFFF, 20'hFFFFF), 1, typed_word(32767, 0, 0)});
    rows.push_back('{1, reading(20'h12345, 20'h00000), 0, '0});
    rows.push_back('{1, reading(20'h00000, 20'h80000), 0, '0});
    rows.push_back('{2, reading(20'h00000, 20'h00000), 0, '0});
    rows.push_back('{2, reading(20'hFFFFF, 20'hFFFFF), 0, '0});
    rows.push_back('{2, reading(20'h00000, 20'hFFFFF), 0, '0});
    rows.push_back('{2, reading(20'hFFFFF, 20'h00000), 0, '0});

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    current_setting = -1;
    use_typed = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].setting != current_setting) begin
        drain();
        current_setting = rows[i].setting;
        load_setting(current_setting);
      end
      if (rows[i].has_typed) typed_results.push_back(rows[i].typed);
      else typed_results.push_back(compensate(rows[i].word));
      send_word(rows[i].word);
    end
    drain();
    use_typed = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      load_setting(ph == 5 ? 0 : (ph == 4 ? 3 : (ph < 3 ? ph + 3 : 4)));
      if (ph == 5) quiet_phase = 1'b1;
      for (int k = 0; k < 185; k++) begin
        if (ph == 1 && k == 20) long_hold = 1'b1;
        if (ph == 2 && k == 90) drain();
        send_word(random_reading());
      end
      drain();
    end

    if (error_count == 0) begin
      $display("tb_pressure_temperature_compensation passed");
    end else begin
      $display("tb_pressure_temperature_compensation failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/ptc_pkg.sv
hdl/ptc_front.sv
hdl/ptc_div.sv
hdl/ptc_back.sv
hdl/pressure_temperature_compensation.sv
dv/tb_pressure_temperature_compensation.sv
